@@ src/settable_clock_with_two_keys_macros.svh @@
// assertion macros shared by the rtl of the settable clock
// no dependencies; included by the modules that carry checks
`ifndef SETTABLE_CLOCK_WITH_TWO_KEYS_MACROS_SVH
`define SETTABLE_CLOCK_WITH_TWO_KEYS_MACROS_SVH

// condition holds at every edge outside reset
`define SCTK_CHECK(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// trigger at one edge implies the condition at the next edge
`define SCTK_CHECK_NEXT(name, trig, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) else $error(msg);

`endif

@@ src/sctk_pkg.sv @@
// shared types, codes and digit helpers for the settable clock
// no dependencies
package sctk_pkg;

   // item kinds on the request side
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SCAN = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_TICKS_PER_SEC = 2'd0;
   localparam logic [1:0] CSR_KEY1_LONG     = 2'd1;
   localparam logic [1:0] CSR_KEY2_LONG     = 2'd2;

   // reset values of the configuration registers
   localparam logic [7:0] TICKS_PER_SEC_RST = 8'd100;
   localparam logic [9:0] KEY1_LONG_RST     = 10'd200;
   localparam logic [9:0] KEY2_LONG_RST     = 10'd150;

   // field selection codes
   localparam logic [1:0] FIELD_SEC = 2'd0;
   localparam logic [1:0] FIELD_MIN = 2'd1;
   localparam logic [1:0] FIELD_HR  = 2'd2;

   // events of one key machine for the current beat
   typedef struct packed {
      logic short_rel;
      logic long_act;
      logic wait_now;
      logic wait_next;
   } key_evt_type;

   // time and mode after the current beat
   typedef struct packed {
      logic [5:0] sec;
      logic [5:0] min;
      logic [4:0] hr;
      logic       set;
      logic [1:0] field;
      logic       run;
   } view_type;

   function automatic logic [2:0] tens_of(input logic [5:0] v);
      logic [2:0] t;
      if (v >= 6'd50)      t = 3'd5;
      else if (v >= 6'd40) t = 3'd4;
      else if (v >= 6'd30) t = 3'd3;
      else if (v >= 6'd20) t = 3'd2;
      else if (v >= 6'd10) t = 3'd1;
      else                 t = 3'd0;
      return t;
   endfunction

   function automatic logic [3:0] ones_of(input logic [5:0] v);
      logic [5:0] base;
      base = {3'b000, tens_of(v)} * 6'd10;
      return 4'(v - base);
   endfunction

endpackage

@@ src/sctk_key.sv @@
// debounce and press-length machine for one key
// depends on sctk_pkg
module sctk_key (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 scan,
   input  logic                 lvl,
   input  logic [9:0]           long_hold,
   input  logic                 long_to_wait,
   output sctk_pkg::key_evt_type evt
);
   import sctk_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_CONFIRM = 3'd1,
      PH_PRESSED = 3'd2,
      PH_LONG    = 3'd3,
      PH_WAIT    = 3'd4
   } phase_type;

   phase_type  phase_ff, phase_nx, phase_in;
   logic [9:0] hold_ff, hold_nx, hold_in, hold_inc;
   logic       short_raw, long_raw;

   assign hold_inc = hold_ff + 10'd1;

   always_comb begin
      phase_nx  = phase_ff;
      hold_nx   = hold_ff;
      short_raw = 1'b0;
      long_raw  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            phase_nx = lvl ? PH_IDLE : PH_CONFIRM;
         end
         PH_CONFIRM: begin
            if (!lvl) begin
               hold_nx  = '0;
               phase_nx = PH_PRESSED;
            end else begin
               phase_nx = PH_IDLE;
            end
         end
         PH_PRESSED: begin
            hold_nx = hold_inc;
            if (lvl) begin
               short_raw = 1'b1;
               phase_nx  = PH_IDLE;
            end else if (hold_inc == long_hold) begin
               hold_nx  = '0;
               phase_nx = PH_LONG;
            end
         end
         PH_LONG: begin
            long_raw = 1'b1;
            phase_nx = (long_to_wait && !lvl) ? PH_WAIT : PH_IDLE;
         end
         PH_WAIT: begin
            if (lvl) phase_nx = PH_IDLE;
         end
         default: begin
            phase_nx = PH_IDLE;
         end
      endcase
   end

   assign phase_in = scan ? phase_nx : phase_ff;
   assign hold_in  = scan ? hold_nx : hold_ff;

   assign evt.short_rel = scan & short_raw;
   assign evt.long_act  = scan & long_raw;
   assign evt.wait_now  = (phase_ff == PH_WAIT);
   assign evt.wait_next = (phase_nx == PH_WAIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hold_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
      end
   end

endmodule

@@ src/sctk_clock.sv @@
// time-of-day counters, prescaler and run/set mode state
// depends on sctk_pkg and the assertion macro header
`include "settable_clock_with_two_keys_macros.svh"

module sctk_clock (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  op,
   input  logic [7:0]            ticks_per_sec,
   input  sctk_pkg::key_evt_type k1,
   input  sctk_pkg::key_evt_type k2,
   output logic                  run_now,
   output logic                  set_mid,
   output sctk_pkg::view_type    view
);
   import sctk_pkg::*;

   logic [7:0] presc_ff, presc_in, presc_inc;
   logic [5:0] sec_ff, sec_in;
   logic [5:0] min_ff, min_in;
   logic [4:0] hr_ff, hr_in;
   logic       run_ff, run_in;
   logic       set_ff, set_in;
   logic [1:0] field_ff, field_in, field_mid;
   logic       tick;

   assign tick      = fire && (op == OP_TICK) && run_ff;
   assign presc_inc = presc_ff + 8'd1;

   // mode after key one, seen by key two in the same beat
   assign set_mid   = k1.long_act ? run_ff : set_ff;
   assign field_mid = (k1.long_act && run_ff) ? FIELD_SEC : field_ff;

   always_comb begin
      presc_in = presc_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hr_in    = hr_ff;
      run_in   = run_ff;
      set_in   = set_mid;
      field_in = field_mid;

      // timer tick
      if (tick) begin
         if (presc_inc == ticks_per_sec) begin
            presc_in = '0;
            if (sec_ff >= 6'd59) begin
               sec_in = '0;
               if (min_ff >= 6'd59) begin
                  min_in = '0;
                  hr_in  = (hr_ff >= 5'd23) ? 5'd0 : 5'(hr_ff + 5'd1);
               end else begin
                  min_in = 6'(min_ff + 6'd1);
               end
            end else begin
               sec_in = 6'(sec_ff + 6'd1);
            end
         end else begin
            presc_in = presc_inc;
         end
      end

      // key one: short release adds with wrap, long toggles run/set
      if (k1.short_rel && set_ff) begin
         case (field_ff)
            FIELD_SEC: sec_in = (sec_in >= 6'd59) ? 6'd0 : 6'(sec_in + 6'd1);
            FIELD_MIN: min_in = (min_in >= 6'd59) ? 6'd0 : 6'(min_in + 6'd1);
            FIELD_HR:  hr_in  = (hr_in >= 5'd23) ? 5'd0 : 5'(hr_in + 5'd1);
            default:   ;
         endcase
      end
      if (k1.long_act) run_in = !run_ff;

      // key two: short release subtracts holding at zero, long cycles field
      if (k2.short_rel && set_mid) begin
         case (field_mid)
            FIELD_SEC: if (sec_in != 6'd0) sec_in = 6'(sec_in - 6'd1);
            FIELD_MIN: if (min_in != 6'd0) min_in = 6'(min_in - 6'd1);
            FIELD_HR:  if (hr_in != 5'd0) hr_in = 5'(hr_in - 5'd1);
            default:   ;
         endcase
      end
      if (k2.long_act && set_mid) begin
         field_in = (field_mid >= FIELD_HR) ? FIELD_SEC : 2'(field_mid + 2'd1);
      end
   end

   assign run_now    = run_ff;
   assign view.sec   = sec_in;
   assign view.min   = min_in;
   assign view.hr    = hr_in;
   assign view.set   = set_in;
   assign view.field = field_in;
   assign view.run   = run_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         presc_ff <= '0;
         sec_ff   <= '0;
         min_ff   <= '0;
         hr_ff    <= '0;
         run_ff   <= 1'b1;
         set_ff   <= 1'b0;
         field_ff <= FIELD_SEC;
      end else begin
         presc_ff <= presc_in;
         sec_ff   <= sec_in;
         min_ff   <= min_in;
         hr_ff    <= hr_in;
         run_ff   <= run_in;
         set_ff   <= set_in;
         field_ff <= field_in;
      end
   end

   `SCTK_CHECK(a_time_in_range, (sec_ff < 6'd60) && (min_ff < 6'd60) && (hr_ff < 5'd24), "time count out of range")
   `SCTK_CHECK(a_set_is_not_run, set_ff != run_ff, "set mode and run flag disagree")
   `SCTK_CHECK(a_field_legal, field_ff != 2'd3, "illegal field selection")
   `SCTK_CHECK_NEXT(a_stopped_holds, fire && (op == OP_TICK) && !run_ff, $stable(presc_ff) && $stable(sec_ff), "stopped clock moved on a tick")

endmodule

@@ src/settable_clock_with_two_keys.sv @@
// top level of the settable time-of-day clock with two keys
// depends on sctk_pkg, sctk_key and sctk_clock
//
// Time-of-day clock, 0:00:00 to 23:59:59, fed a stream of beats: a timer
// tick (tuser 0) or a key scan (tuser 1) carrying both key levels, 0 pressed.
// Every request beat yields exactly one response beat with the time digits
// and mode after that beat. A beat is registered on entry, processed in one
// pass of short logic into the response register, from which it can be taken;
// one beat is taken every cycle while the response side does not stall.
// Backpressure on the response side stalls the input register only when both
// stages are full. Configuration: csr index 0 ticks per second (reset 100),
// 1 key one long-press scans (reset 200), 2 key two long-press scans
// (reset 150); write only while idle. A long key one toggles run/set mode, a
// long key two steps the selected field in set mode, short presses add (key
// one, wrapping) or subtract (key two, holding at zero).
module settable_clock_with_two_keys (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // key1_level, key2_level, zero pad
   input  logic        req_tuser,   // op
   // response side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // hours_tens, hours_ones, minutes_tens, minutes_ones,
                                    // seconds_tens, seconds_ones, in_set_mode,
                                    // selected_field, clock_running
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [9:0]  csr_wdata
);
   import sctk_pkg::*;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic        in_op_ff, in_k1_ff, in_k2_ff;
   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   // configuration registers
   logic [7:0]  tps_ff;
   logic [9:0]  k1_long_ff, k2_long_ff;

   logic        rsp_free, fire, scan1, scan2;
   logic        run_now, set_mid;
   key_evt_type k1_evt, k2_evt;
   view_type    view;

   // response stage can take a beat when empty or draining
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && rsp_free;
   assign req_tready = !in_valid_ff || rsp_free;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // a key two in wait-release freezes key one; a key one left in wait-release
   // freezes key two for this beat, unless key two is itself in wait-release
   assign scan1 = fire && (in_op_ff == OP_SCAN) && !k2_evt.wait_now;
   assign scan2 = fire && (in_op_ff == OP_SCAN) && (k2_evt.wait_now || !k1_evt.wait_next);

   sctk_key u_key1 (
      .clock        (clock),
      .reset        (reset),
      .scan         (scan1),
      .lvl          (in_k1_ff),
      .long_hold    (k1_long_ff),
      .long_to_wait (run_now),
      .evt          (k1_evt)
   );

   sctk_key u_key2 (
      .clock        (clock),
      .reset        (reset),
      .scan         (scan2),
      .lvl          (in_k2_ff),
      .long_hold    (k2_long_ff),
      .long_to_wait (set_mid),
      .evt          (k2_evt)
   );

   sctk_clock u_clock (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .op            (in_op_ff),
      .ticks_per_sec (tps_ff),
      .k1            (k1_evt),
      .k2            (k2_evt),
      .run_now       (run_now),
      .set_mid       (set_mid),
      .view          (view)
   );

   // pack the response beat, highest field first
   assign rsp_data_in = {view.run, view.field, view.set,
                         ones_of(view.sec), tens_of(view.sec),
                         ones_of(view.min), tens_of(view.min),
                         ones_of({1'b0, view.hr}), 2'(tens_of({1'b0, view.hr}))};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tps_ff       <= TICKS_PER_SEC_RST;
         k1_long_ff   <= KEY1_LONG_RST;
         k2_long_ff   <= KEY2_LONG_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_TICKS_PER_SEC: tps_ff     <= csr_wdata[7:0];
               CSR_KEY1_LONG:     k1_long_ff <= csr_wdata;
               CSR_KEY2_LONG:     k2_long_ff <= csr_wdata;
               default:           ;
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_op_ff <= req_tuser;
         in_k1_ff <= req_tdata[0];
         in_k2_ff <= req_tdata[1];
      end
      if (fire) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
